// File: rtl/core/gbb_pkg.sv
package gbb_pkg;

	// Screen and font geometry
	localparam int FB_WIDTH    = 240;
	localparam int FB_HEIGHT   = 240;
	localparam int FONT_BYTES  = 4096;
	localparam int MAX_GLYPH_W = 32;
	localparam int MAX_GLYPH_H = 32;

	// Effective size limits: a row mask never exceeds 32 pixels
	localparam int W_CAP = (MAX_GLYPH_W < 32) ? MAX_GLYPH_W : 32;
	localparam int H_CAP = (MAX_GLYPH_H < 32) ? MAX_GLYPH_H : 32;

	// Font store addressing (store depth is a power of two)
	localparam int FONT_AW = $clog2(FONT_BYTES);

	// Exact row start width: covers pen, offset and up to 32 rows at any width
	localparam int START_W = 24;
	localparam int FB_SIZE = FB_WIDTH * FB_HEIGHT;

	// Saturation range of the row start output
	localparam int ROW_MIN = -262144;
	localparam int ROW_MAX = 262143;

	// Bit buffer: up to 31 pending bits plus one fresh byte
	localparam int BUF_W = 40;

	// Input selector codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROW  = 3'b010,
		ST_FILL = 3'b100
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture; // latch draw fields, clear bit buffer
		logic rd;      // read next font byte, advance address
		logic fill;    // append read byte to bit buffer
		logic emit;    // write row word to output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic enough;    // bit buffer holds a whole row
		logic last_row;  // current row is the glyph's final row
		logic in_h_zero; // offered draw word has no rows
		logic out_free;  // output register can take a word this cycle
	} dp_sts_t;

endpackage

// File: rtl/core/gbb_ram.sv
module gbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one entry, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/core/gbb_ctrl.sv
module gbb_ctrl import gbb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_cmd,
	input  dp_sts_t sts,
	output logic    in_ready,
	output dp_cmd_t cmd
);

	state_t state_q, state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Sequence rows and byte fetches
	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_cmd == CMD_DRAW) begin
					cmd.capture = 1'b1;
					if (!sts.in_h_zero) begin
						state_nxt = ST_ROW;
					end
				end
			end
			ST_ROW: begin
				if (sts.enough) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						if (sts.last_row) begin
							state_nxt = ST_IDLE;
						end
					end
				end else begin
					cmd.rd    = 1'b1;
					state_nxt = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill  = 1'b1;
				state_nxt = ST_ROW;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/core/gbb_datapath.sv
module gbb_datapath import gbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        in_cmd,
	input  logic [95:0] in_data,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [63:0] out_data,
	output logic        out_user,
	output logic        out_last
);

	// Input word fields
	logic [11:0]        f_load_addr;
	logic [7:0]         f_load_byte;
	logic [11:0]        f_bitmap_offset;
	logic [5:0]         f_glyph_width;
	logic [5:0]         f_glyph_height;
	logic signed [7:0]  f_x_offset;
	logic signed [7:0]  f_y_offset;
	logic signed [10:0] f_pen_x;
	logic signed [10:0] f_pen_y;
	logic [7:0]         f_color;

	assign f_load_addr     = in_data[11:0];
	assign f_load_byte     = in_data[19:12];
	assign f_bitmap_offset = in_data[31:20];
	assign f_glyph_width   = in_data[37:32];
	assign f_glyph_height  = in_data[43:38];
	assign f_x_offset      = in_data[51:44];
	assign f_y_offset      = in_data[59:52];
	assign f_pen_x         = in_data[70:60];
	assign f_pen_y         = in_data[81:71];
	assign f_color         = in_data[89:82];

	// Glyph state
	logic [FONT_AW-1:0]        addr_q;
	logic [5:0]                w_q;
	logic [5:0]                h_q;
	logic [5:0]                row_q;
	logic [7:0]                color_q;
	logic signed [START_W-1:0] start_q;
	logic [BUF_W-1:0]          buf_q;
	logic [5:0]                cnt_q;

	// Output register
	logic        ovalid_q;
	logic [18:0] orow_q;
	logic [31:0] omask_q;
	logic [7:0]  opix_q;
	logic        ooff_q;
	logic        olast_q;

	// Font store
	logic                we;
	logic [FONT_AW-1:0]  ram_addr;
	logic [7:0]          ram_rdata;

	assign we       = in_valid && in_ready && (in_cmd == CMD_LOAD);
	assign ram_addr = we ? FONT_AW'(f_load_addr) : addr_q;

	gbb_ram #(
		.WIDTH(8),
		.DEPTH(FONT_BYTES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.addr (ram_addr),
		.wdata(f_load_byte),
		.rdata(ram_rdata)
	);

	// Saturate glyph size
	logic [5:0] w_sat, h_sat;
	assign w_sat = (f_glyph_width  > 6'(W_CAP)) ? 6'(W_CAP) : f_glyph_width;
	assign h_sat = (f_glyph_height > 6'(H_CAP)) ? 6'(H_CAP) : f_glyph_height;

	// First row start: x0 + y0 * width
	logic signed [11:0]        x0, y0;
	logic signed [START_W-1:0] start0;
	assign x0     = 12'(f_pen_x) + 12'(f_x_offset);
	assign y0     = 12'(f_pen_y) + 12'(f_y_offset);
	assign start0 = START_W'(y0) * START_W'(FB_WIDTH) + START_W'(x0);

	// Row mask: stream bits MSB first, column 0 in bit 0
	logic [31:0] mask;
	always_comb begin
		for (int c = 0; c < 32; c++) begin
			mask[c] = (6'(c) < w_q) && buf_q[BUF_W-1-c];
		end
	end

	// Thermometer code: bits below n set, n in 0..32
	function automatic logic [31:0] therm(input logic [5:0] n);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = (6'(i) < n);
		end
		return r;
	endfunction

	// Off-screen: set pixels left of index 0 or at or past the frame end
	logic signed [START_W-1:0] neg_start, room;
	logic [5:0]                lo_n, hi_n;
	logic                      off;
	assign neg_start = -start_q;
	assign room      = START_W'(FB_SIZE) - start_q;
	always_comb begin
		if (neg_start <= 0) begin
			lo_n = 6'd0;
		end else if (neg_start >= 32) begin
			lo_n = 6'd32;
		end else begin
			lo_n = neg_start[5:0];
		end
		if (room <= 0) begin
			hi_n = 6'd0;
		end else if (room >= 32) begin
			hi_n = 6'd32;
		end else begin
			hi_n = room[5:0];
		end
	end
	assign off = |(mask & (therm(lo_n) | ~therm(hi_n)));

	// Saturate row start for output
	logic [18:0] row_sat;
	always_comb begin
		if (start_q < START_W'(ROW_MIN)) begin
			row_sat = 19'(ROW_MIN);
		end else if (start_q > START_W'(ROW_MAX)) begin
			row_sat = 19'(ROW_MAX);
		end else begin
			row_sat = start_q[18:0];
		end
	end

	// Status back to the controller
	assign sts.enough    = (cnt_q >= w_q);
	assign sts.last_row  = (6'(row_q + 6'd1) == h_q);
	assign sts.in_h_zero = (f_glyph_height == 6'd0);
	assign sts.out_free  = !ovalid_q || out_ready;

	// Glyph state: capture, fetch, fill and advance a row
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q  <= FONT_AW'(f_bitmap_offset);
			w_q     <= w_sat;
			h_q     <= h_sat;
			row_q   <= 6'd0;
			color_q <= f_color;
			start_q <= start0;
			buf_q   <= '0;
			cnt_q   <= 6'd0;
		end
		if (cmd.rd) begin
			addr_q <= addr_q + FONT_AW'(1);
		end
		if (cmd.fill) begin
			buf_q <= buf_q | ({ram_rdata, 32'b0} >> cnt_q);
			cnt_q <= cnt_q + 6'd8;
		end
		if (cmd.emit) begin
			buf_q   <= buf_q << w_q;
			cnt_q   <= cnt_q - w_q;
			row_q   <= row_q + 6'd1;
			start_q <= start_q + START_W'(FB_WIDTH);
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			orow_q  <= row_sat;
			omask_q <= mask;
			opix_q  <= color_q;
			ooff_q  <= off;
			olast_q <= sts.last_row;
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = {5'b0, opix_q, omask_q, orow_q};
	assign out_user  = ooff_q;
	assign out_last  = olast_q;

endmodule

// File: rtl/core/glyph_bitmap_blitter.sv
// Packed 1-bit-per-pixel glyph blitter. A word with s_tuser low writes one
// byte into the 4096-byte font store. A word with s_tuser high draws a glyph:
// its bitmap is read MSB first as one bit stream running across rows, and one
// output word per glyph row gives the saturated linear framebuffer index of
// the row start, the set-pixel mask (bit i is pixel start+i), the colour, an
// off-screen flag (m_tuser) and m_tlast on the final row. A draw fetches
// ceil(W*H/8) bytes one at a time over the single store port, whose read data
// is registered; a stalled output holds the draw, and no new word is taken
// until its final row has been written to the output register. The store has
// no reset: a glyph must only read bytes that were loaded.
module glyph_bitmap_blitter import gbb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata, lowest bit up: load_addr, load_byte, bitmap_offset,
	// glyph_width, glyph_height, x_offset, y_offset, pen_x, pen_y, color
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        s_tuser,  // cmd
	// m_tdata, lowest bit up: row_start, row_mask, pixel_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,
	output logic        m_tuser,  // off_screen
	output logic        m_tlast
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	gbb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_cmd  (s_tuser),
		.sts     (sts),
		.in_ready(s_tready),
		.cmd     (cmd)
	);

	gbb_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_data  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data (m_tdata),
		.out_user (m_tuser),
		.out_last (m_tlast)
	);

`ifndef SYNTHESIS
	// A row word is written only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("row emitted into a full output register");

	// Fetch and emit never share a cycle
	a_rd_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd && cmd.emit))
		else $error("byte fetch and row emit together");

	// After the final row the block is ready for the next word
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last_row) |=> s_tready)
		else $error("not idle after final row");

	// No datapath work while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.rd || cmd.fill || cmd.emit))
		else $error("datapath command while idle");
`endif

endmodule

// File: sim/tb_glyph_bitmap_blitter.sv
`timescale 1ns / 100ps

module tb_glyph_bitmap_blitter;
	import gbb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_OFF_CYCLES = 500;

	// One input word, fields as unpacked from s_tdata and s_tuser
	typedef struct {
		logic               cmd;
		logic [11:0]        load_addr;
		logic [7:0]         load_byte;
		logic [11:0]        bitmap_offset;
		logic [5:0]         glyph_width;
		logic [5:0]         glyph_height;
		logic signed [7:0]  x_offset;
		logic signed [7:0]  y_offset;
		logic signed [10:0] pen_x;
		logic signed [10:0] pen_y;
		logic [7:0]         color;
	} glyph_item_t;

	// One expected glyph row
	typedef struct {
		logic signed [18:0] start;
		logic [31:0]        mask;
		logic [7:0]         pixel;
		logic               off;
		logic               last;
	} glyph_row_t;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_EVERY_THIRD
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic [7:0]   font_mem [FONT_BYTES];
	bit           font_loaded [FONT_BYTES];
	glyph_row_t   pending_rows [$];
	int           mismatches;
	int           cycle_cnt;
	int           burst_left;
	int           hold_cycles;
	int           rx_left;
	rx_mode_t     rx_mode;

	glyph_bitmap_blitter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_glyph_bitmap_blitter NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 50)
			$display("%0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [95:0] pack_item(glyph_item_t it);
		return {6'd0, it.color, it.pen_y, it.pen_x, it.y_offset, it.x_offset,
			it.glyph_height, it.glyph_width, it.bitmap_offset, it.load_byte,
			it.load_addr};
	endfunction

	function automatic int glyph_bytes(glyph_item_t it);
		int w;
		int h;
		w = (it.glyph_width > W_CAP) ? W_CAP : it.glyph_width;
		h = (it.glyph_height > H_CAP) ? H_CAP : it.glyph_height;
		return (w * h + 7) / 8;
	endfunction

	// Unpack the glyph bit stream and queue one expected row per glyph row
	function automatic void predict_glyph_rows(glyph_item_t it);
		int         w;
		int         h;
		int         addr;
		int         bitpos;
		longint     x0;
		longint     y0;
		longint     start;
		longint     clipped;
		longint     idx;
		logic [7:0] cur;
		glyph_row_t r;
		w = (it.glyph_width > W_CAP) ? W_CAP : it.glyph_width;
		h = (it.glyph_height > H_CAP) ? H_CAP : it.glyph_height;
		x0 = longint'(it.pen_x) + longint'(it.x_offset);
		y0 = longint'(it.pen_y) + longint'(it.y_offset);
		addr = int'(it.bitmap_offset);
		bitpos = 0;
		cur = '0;
		for (int row = 0; row < h; row++) begin
			start = x0 + (y0 + row) * FB_WIDTH;
			r.mask = '0;
			r.off = 1'b0;
			for (int col = 0; col < w; col++) begin
				if (bitpos % 8 == 0) begin
					cur = font_mem[addr];
					addr = (addr + 1) % FONT_BYTES;
				end
				if (cur[7]) begin
					idx = start + col;
					r.mask[col] = 1'b1;
					if (idx < 0 || idx >= FB_SIZE)
						r.off = 1'b1;
				end
				cur = cur << 1;
				bitpos++;
			end
			clipped = start;
			if (clipped < ROW_MIN)
				clipped = ROW_MIN;
			if (clipped > ROW_MAX)
				clipped = ROW_MAX;
			r.start = clipped[18:0];
			r.pixel = it.color;
			r.last = (row == h - 1);
			pending_rows.push_back(r);
		end
	endfunction

	// Offer one word in bursts with random gaps, then apply it to the model
	task automatic send_item(input glyph_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= pack_item(it);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (it.cmd == CMD_LOAD) begin
			font_mem[it.load_addr] = it.load_byte;
			font_loaded[it.load_addr] = 1'b1;
		end else begin
			predict_glyph_rows(it);
		end
	endtask

	function automatic glyph_item_t make_load(int addr, int value);
		glyph_item_t it;
		it.cmd = CMD_LOAD;
		it.load_addr = 12'(addr);
		it.load_byte = 8'(value);
		// fill the unused draw fields with noise
		it.bitmap_offset = 12'($urandom());
		it.glyph_width = 6'($urandom());
		it.glyph_height = 6'($urandom());
		it.x_offset = 8'($urandom());
		it.y_offset = 8'($urandom());
		it.pen_x = 11'($urandom());
		it.pen_y = 11'($urandom());
		it.color = 8'($urandom());
		return it;
	endfunction

	function automatic glyph_item_t make_draw(int offset, int w, int h, int xo,
			int yo, int px, int py, int col);
		glyph_item_t it;
		it.cmd = CMD_DRAW;
		it.load_addr = 12'($urandom());
		it.load_byte = 8'($urandom());
		it.bitmap_offset = 12'(offset);
		it.glyph_width = 6'(w);
		it.glyph_height = 6'(h);
		it.x_offset = 8'(xo);
		it.y_offset = 8'(yo);
		it.pen_x = 11'(px);
		it.pen_y = 11'(py);
		it.color = 8'(col);
		return it;
	endfunction

	// Load any bitmap byte the glyph needs that was never written, then draw
	task automatic draw_glyph(input glyph_item_t it);
		int nbytes;
		int a;
		nbytes = glyph_bytes(it);
		for (int n = 0; n < nbytes; n++) begin
			a = (it.bitmap_offset + n) % FONT_BYTES;
			if (!font_loaded[a])
				send_item(make_load(a, $urandom_range(0, 255)));
		end
		send_item(it);
	endtask

	function automatic glyph_item_t rand_draw();
		int pick;
		int offset;
		int w;
		int h;
		int xo;
		int yo;
		int px;
		int py;
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			w = $urandom_range(0, 12);
			h = $urandom_range(0, 10);
		end else if (pick < 95) begin
			w = $urandom_range(0, 32);
			h = $urandom_range(0, 32);
		end else begin
			w = $urandom_range(0, 63);
			h = $urandom_range(0, 63);
		end
		// stay mostly on bytes that are already loaded to keep the load count low
		pick = $urandom_range(0, 99);
		if (pick < 75)
			offset = $urandom_range(192, 320);
		else if (pick < 95)
			offset = $urandom_range(3990, 4095);
		else
			offset = $urandom_range(0, 4095);
		// keep most glyphs near the screen so both flag values turn up
		if ($urandom_range(0, 4) == 0) begin
			xo = $urandom();
			yo = $urandom();
			px = $urandom();
			py = $urandom();
		end else begin
			xo = $urandom_range(0, 16) - 8;
			yo = $urandom_range(0, 24) - 20;
			px = $urandom_range(0, 250) - 5;
			py = $urandom_range(0, 250) - 5;
		end
		return make_draw(offset, w, h, xo, yo, px, py, $urandom_range(0, 255));
	endfunction

	// Drop valid and hold until every expected row has come back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_rows.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_font_load();
		send_item(make_load(0, 8'hFF));
		send_item(make_load(4095, 8'hA5));
		send_item(make_load(1, 8'h00));
		send_item(make_load(2, 8'h81));
		// bit stream wraps from the top of the store to address zero
		draw_glyph(make_draw(4095, 9, 2, 0, 0, 10, 10, 8'h55));
	endtask

	task automatic test_empty_glyphs();
		draw_glyph(make_draw(0, 5, 0, 0, 0, 20, 20, 8'h11));
		draw_glyph(make_draw(0, 0, 4, 0, 0, -3, 5, 8'h22));
		draw_glyph(make_draw(0, 0, 0, 0, 0, 0, 0, 8'h33));
	endtask

	task automatic test_oversize();
		draw_glyph(make_draw(256, 32, 32, 0, 0, 100, 100, 8'hC3));
		// width and height beyond the cap saturate to it
		draw_glyph(make_draw(256, 63, 63, 0, 0, 100, 100, 8'h3C));
		draw_glyph(make_draw(256, 40, 3, 5, -2, 50, 60, 8'h7E));
	endtask

	task automatic test_row_saturation();
		draw_glyph(make_draw(0, 8, 3, -128, -128, -1024, -1024, 8'h01));
		draw_glyph(make_draw(0, 8, 3, 127, 127, 1023, 1023, 8'h80));
		draw_glyph(make_draw(256, 32, 2, -128, 127, -1024, 1023, 8'hFE));
	endtask

	task automatic test_screen_edges();
		draw_glyph(make_draw(256, 32, 2, 0, 0, 0, 0, 8'h00));
		draw_glyph(make_draw(256, 16, 4, 0, 0, 230, 238, 8'hFF));
		draw_glyph(make_draw(256, 16, 4, 0, 0, -5, -1, 8'h99));
		draw_glyph(make_draw(256, 7, 5, 0, 0, 233, 0, 8'h44));
		draw_glyph(make_draw(256, 1, 6, 0, 0, 239, 236, 8'h66));
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_item(make_load($urandom_range(0, 4095), $urandom_range(0, 255)));
			else
				draw_glyph(rand_draw());
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 10; i++)
			draw_glyph(rand_draw());
		wait_drain();
		for (int i = 0; i < 10; i++)
			draw_glyph(rand_draw());
	endtask

	task automatic test_backpressure();
		hold_cycles = HOLD_OFF_CYCLES;
		for (int i = 0; i < 30; i++)
			draw_glyph(make_draw($urandom_range(256, 300), $urandom_range(4, 16),
				$urandom_range(4, 12), 0, 0, $urandom_range(0, 230),
				$urandom_range(0, 230), $urandom_range(0, 255)));
	endtask

	// Drive ready on a changing pattern, or hold it off when asked
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 60);
			end
			rx_left--;
			case (rx_mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_COIN: m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_left % 3 == 0);
			endcase
		end
	end

	// Compare each accepted row word with the oldest expectation
	always @(posedge clk) begin
		glyph_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rows.size() == 0) begin
				report_mismatch("unexpected row word", m_tdata, '0);
			end else begin
				want = pending_rows.pop_front();
				if (m_tdata[18:0] !== want.start)
					report_mismatch("row_start", 64'(m_tdata[18:0]),
						{45'd0, want.start});
				if (m_tdata[50:19] !== want.mask)
					report_mismatch("row_mask", 64'(m_tdata[50:19]), 64'(want.mask));
				if (m_tdata[58:51] !== want.pixel)
					report_mismatch("pixel_value", 64'(m_tdata[58:51]),
						64'(want.pixel));
				if (m_tuser !== want.off)
					report_mismatch("off_screen", 64'(m_tuser), 64'(want.off));
				if (m_tlast !== want.last)
					report_mismatch("last", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LOAD;
		m_tready = 1'b0;
		mismatches = 0;
		cycle_cnt = 0;
		burst_left = 0;
		hold_cycles = 0;
		rx_left = 0;
		rx_mode = RX_ALWAYS;
		foreach (font_loaded[i])
			font_loaded[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_font_load();
		test_empty_glyphs();
		test_oversize();
		test_row_saturation();
		test_screen_edges();
		test_random(40);
		test_drain_pause();
		test_backpressure();
		test_random(40);

		// let the last draw finish even if it gave no rows
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_rows.size() == 0)
			$display("tb_glyph_bitmap_blitter OK");
		else
			$display("tb_glyph_bitmap_blitter NOT OK");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/gbb_pkg.sv
rtl/core/gbb_ram.sv
rtl/core/gbb_ctrl.sv
rtl/core/gbb_datapath.sv
rtl/core/glyph_bitmap_blitter.sv
sim/tb_glyph_bitmap_blitter.sv
